// ----- rtl/core/chebk0_pkg.sv -----
// ----------------------------------------------------------------------------
// chebk0_pkg
// Shared constants for the Chebyshev K0 series evaluator.
// ----------------------------------------------------------------------------
package chebk0_pkg;

    localparam int unsigned MAX_TERMS_DEF = 32;

    localparam int unsigned X_W    = 32;  // Q16.16
    localparam int unsigned COEF_W = 32;  // Q2.30
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned TC_W   = 5;
    localparam int unsigned SUM_W  = 48;  // Q18.30
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_POINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT  = 2'd1;

    localparam logic [X_W-1:0]  SPLIT_RESET = 32'd65536;
    localparam logic [TC_W-1:0] TERMS_RESET = 5'd20;

    localparam logic [0:0] REQ_WRITE = 1'b0;
    localparam logic [0:0] REQ_EVAL  = 1'b1;

    typedef logic [X_W-1:0] t_word;

endpackage

// ----- rtl/core/chebk0_ram.sv -----
// ----------------------------------------------------------------------------
// chebk0_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module chebk0_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/chebyshev_k0_series_eval_top.sv -----
// An evaluate with x below the split point answers in the cycle after the
// transfer; otherwise it runs the divider and then the recurrence, with one
// coefficient read per cycle (N <= 31).
// One item at a time; a new item is taken once the previous result is gone.
// Reset (synchronous, active low) restores the control and configuration
// registers only; the coefficient table holds no defined value until written.
// ----------------------------------------------------------------------------
// chebyshev_k0_series_eval_top
// Chebyshev series evaluator for the scaled Bessel K0 tail, fixed point.
// ----------------------------------------------------------------------------
module chebyshev_k0_series_eval_top #(
    parameter int unsigned MAX_TERMS = chebk0_pkg::MAX_TERMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_req_type,
    input  logic [chebk0_pkg::IDX_W-1:0]         i_coef_index,
    input  logic signed [chebk0_pkg::COEF_W-1:0] i_coef_value,
    input  logic [chebk0_pkg::X_W-1:0]           i_x_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [chebk0_pkg::SUM_W-1:0]  o_series_sum,
    output logic                                 o_range_error,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [chebk0_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [chebk0_pkg::X_W-1:0]           i_cfg_data
);
    import chebk0_pkg::*;

    localparam int unsigned AW = $clog2(MAX_TERMS);
    localparam int unsigned KW = (AW > IDX_W) ? AW : IDX_W;
    localparam int unsigned TW = 36;   // recurrence terms, Q6.30
    localparam int unsigned AccW = 56;
    localparam logic [KW-1:0] K_LAST = KW'(MAX_TERMS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_TSET  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic signed [TW-1:0]   ONE_T   = TW'(64'sd1 << 30);
    localparam logic signed [AccW-1:0] SUM_MAX = AccW'((64'sd1 <<< 47) - 64'sd1);
    localparam logic signed [AccW-1:0] SUM_MIN = -AccW'(64'sd1 <<< 47);

    logic [2:0]  r_state;
    t_word       r_split;
    logic [TC_W-1:0] r_terms;

    t_word       r_x;
    logic        r_xzero;
    logic        r_dlsb;
    logic [31:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0]  r_cnt;

    logic signed [31:0]     r_t;
    logic signed [TW-1:0]   r_cur;
    logic signed [TW-1:0]   r_prev;
    logic [AW-1:0]          r_k;
    logic [AW-1:0]          r_nlim;
    logic signed [67:0]     r_prod;
    logic                   r_pvalid;
    logic signed [AccW-1:0] r_acc;

    logic                   r_ovalid;
    logic signed [SUM_W-1:0] r_osum;
    logic                   r_oerr;
    logic                   r_osat;

    logic                in_xfer;
    logic [32:0]         trial;
    logic                trial_ge;
    logic [KW-1:0]       idx_ext;
    logic [KW-1:0]       tc_ext;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic signed [COEF_W-1:0] ram_rdata;
    logic signed [67:0]  tprod;
    logic signed [38:0]  tround;
    logic signed [TW-1:0] t_next;
    logic signed [37:0]  term_rnd;
    logic signed [32:0]  t_wide;

    assign o_ready     = (r_state == ST_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_valid && o_ready;

    assign idx_ext = KW'(i_coef_index);
    assign tc_ext  = KW'(r_terms);

    assign trial    = {r_rem, (r_cnt == 6'd0) ? r_dlsb : 1'b0};
    assign trial_ge = trial >= {1'b0, r_x};

    assign tprod  = r_t * r_cur;
    assign tround = 39'((tprod + (68'sd1 <<< 28)) >>> 29);
    assign t_next = TW'(tround - 39'(r_prev));

    assign term_rnd = 38'((r_prod + (68'sd1 <<< 29)) >>> 30);
    assign t_wide   = r_xzero ? -33'sd1073741824
                              : $signed({1'b0, r_quo[32:1]}) - 33'sd1073741824;

    assign ram_we = in_xfer && (i_req_type == REQ_WRITE) && (idx_ext <= K_LAST);
    always_comb begin
        if (r_state == ST_IDLE) begin
            ram_addr = idx_ext[AW-1:0];
        end else if (r_state == ST_TSET) begin
            ram_addr = '0;
        end else begin
            ram_addr = r_k + AW'(1);
        end
    end

    chebk0_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_coef_value),
        .o_rdata (ram_rdata)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= SPLIT_RESET;
            r_terms <= TERMS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPLIT_POINT: r_split <= i_cfg_data;
                CFG_TERM_COUNT:  r_terms <= i_cfg_data[TC_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer && i_req_type == REQ_EVAL) begin
                        if (i_x_value < r_split) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (r_cnt == 6'd32) begin
                        r_state <= ST_TSET;
                    end
                end
                ST_TSET: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_pvalid <= 1'b1;
                    if (r_k == r_nlim) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_pvalid <= 1'b0;
                    r_state  <= ST_DONE;
                end
                ST_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x     <= i_x_value;
                r_xzero <= (i_x_value == '0);
                r_rem   <= {1'b0, r_split[31:1]};
                r_dlsb  <= r_split[0];
                r_quo   <= '0;
                r_cnt   <= '0;
                r_nlim  <= (tc_ext > K_LAST) ? K_LAST[AW-1:0] : tc_ext[AW-1:0];
                if (in_xfer && i_x_value < r_split) begin
                    r_osum <= '0;
                    r_oerr <= 1'b1;
                    r_osat <= 1'b0;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                r_rem <= trial_ge ? 32'(trial - {1'b0, r_x}) : trial[31:0];
                r_quo <= {r_quo[31:0], trial_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            ST_TSET: begin
                r_t    <= 32'(t_wide);
                r_cur  <= ONE_T;
                r_prev <= TW'(t_wide);
                r_k    <= '0;
                r_acc  <= '0;
            end
            ST_RUN: begin
                r_prod <= ram_rdata * r_cur;
                r_cur  <= t_next;
                r_prev <= r_cur;
                r_k    <= r_k + AW'(1);
            end
            ST_DONE: begin
                r_oerr <= 1'b0;
                if (r_acc > SUM_MAX) begin
                    r_osum <= SUM_MAX[SUM_W-1:0];
                    r_osat <= 1'b1;
                end else if (r_acc < SUM_MIN) begin
                    r_osum <= SUM_MIN[SUM_W-1:0];
                    r_osat <= 1'b1;
                end else begin
                    r_osum <= r_acc[SUM_W-1:0];
                    r_osat <= 1'b0;
                end
            end
            default: ;
        endcase
        if (r_pvalid) begin
            r_acc <= r_acc + AccW'(term_rnd);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_series_sum  = r_osum;
    assign o_range_error = r_oerr;
    assign o_saturated   = r_osat;
endmodule
